// ===== design/gtmac_pkg.sv =====
// ----------------------------------------------------------------------------
// gtmac_pkg: shared types and constants of the 4x4 GEMM tile MAC
// Request modes, register indexes, fixed-point widths, saturation bounds and
// the records passed between the cells, the output scaler and the top level.
// ----------------------------------------------------------------------------
package gtmac_pkg;

   // fixed-point field widths
   localparam int DATA_BITS = 16;                 // A, B, alpha, beta (Q8.8)
   localparam int PROD_BITS = 2 * DATA_BITS;      // exact Q16.16 product
   localparam int C_BITS    = 32;                 // C elements (Q16.16)
   localparam int IDX_BITS  = 2;                  // tile row / column fields
   localparam int LANES     = 4;                  // operand lanes per request

   // parameter defaults
   localparam int TILE_DIM_DEF = 4;
   localparam int ACC_BITS_DEF = 48;

   // output scaler: accumulator magnitude handled exactly, split for multiply
   localparam int MAG_BITS   = 48;
   localparam int SPLIT_BITS = 24;
   localparam int WIDE_BITS  = 64;
   localparam logic signed [WIDE_BITS-1:0] BIG_POS = 64'sh0000_8000_0000_0000;
   localparam logic signed [WIDE_BITS-1:0] BIG_NEG = 64'shFFFF_8000_0000_0000;
   localparam logic [C_BITS-1:0] C_MAX = 32'h7FFF_FFFF;
   localparam logic [C_BITS-1:0] C_MIN = 32'h8000_0000;

   // request modes
   localparam logic [1:0] MODE_ACC   = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_EMIT  = 2'd2;
   localparam logic [1:0] MODE_NONE  = 2'd3;

   // configuration registers
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ALPHA = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BETA  = 1'd1;
   localparam logic signed [DATA_BITS-1:0] ALPHA_RESET = 16'sd256;
   localparam logic signed [DATA_BITS-1:0] BETA_RESET  = 16'sd0;

   // token and A operand handed from cell to cell along a row
   typedef struct packed {
      logic                        fire;
      logic                        clear;
      logic signed [DATA_BITS-1:0] a;
   } gtmac_link_type;

   // one finished C element
   typedef struct packed {
      logic [C_BITS-1:0]   c_new;
      logic [IDX_BITS-1:0] row;
      logic [IDX_BITS-1:0] col;
   } gtmac_result_type;

endpackage

// ===== design/gtmac_cell.sv =====
// ----------------------------------------------------------------------------
// gtmac_cell: one multiply-accumulate cell of the tile
// Multiplies the A operand arriving from its left neighbor by its own B
// operand, adds the product into its saturating accumulator in the next cycle
// and hands the token and the A operand on to its right neighbor.
// ----------------------------------------------------------------------------
module gtmac_cell #(
   parameter int ACC_BITS = gtmac_pkg::ACC_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  gtmac_pkg::gtmac_link_type                 link_in,
   input  logic signed [gtmac_pkg::DATA_BITS-1:0]    b_in,
   output gtmac_pkg::gtmac_link_type                 link_out,
   output logic signed [ACC_BITS-1:0]                acc_out
);
   import gtmac_pkg::*;

   logic                        fire_ff;
   logic                        clear_ff;
   logic signed [DATA_BITS-1:0] a_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [PROD_BITS-1:0] prod_in;
   logic signed [ACC_BITS-1:0]  acc_ff;
   logic signed [ACC_BITS-1:0]  acc_in;
   logic signed [ACC_BITS-1:0]  base;
   logic signed [ACC_BITS:0]    sum;
   logic signed [ACC_BITS-1:0]  acc_max;
   logic signed [ACC_BITS-1:0]  acc_min;

   // product of the passing A operand and this cell's B operand
   assign prod_in = $signed(link_in.a) * b_in;

   // add into the accumulator, restart from zero on clear, saturate
   always_comb begin
      acc_max = {1'b0, {(ACC_BITS-1){1'b1}}};
      acc_min = {1'b1, {(ACC_BITS-1){1'b0}}};
      base    = clear_ff ? '0 : acc_ff;
      sum     = (ACC_BITS+1)'(base) + (ACC_BITS+1)'(prod_ff);
      if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
         acc_in = sum[ACC_BITS] ? acc_min : acc_max;
      end else begin
         acc_in = sum[ACC_BITS-1:0];
      end
   end

   // control and accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         fire_ff  <= 1'b0;
         clear_ff <= 1'b0;
         acc_ff   <= '0;
      end else begin
         fire_ff  <= link_in.fire;
         clear_ff <= link_in.clear;
         if (fire_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

   // operand and product registers
   always_ff @(posedge clock) begin
      a_ff <= link_in.a;
      if (link_in.fire) begin
         prod_ff <= prod_in;
      end
   end

   // hand the token and operand to the next cell
   assign link_out = '{fire: fire_ff, clear: clear_ff, a: a_ff};
   assign acc_out  = acc_ff;

endmodule

// ===== design/gtmac_scale.sv =====
// ----------------------------------------------------------------------------
// gtmac_scale: output scaler of the tile
// Four stages: range check of the accumulator, split multiply by alpha and
// multiply of the old C element by beta, wide sum, then floor by 256 and
// saturation to 32 bits. The last stage holds until the result is taken.
// ----------------------------------------------------------------------------
module gtmac_scale #(
   parameter int ACC_BITS = gtmac_pkg::ACC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    go,
   input  logic signed [ACC_BITS-1:0]              acc,
   input  logic signed [gtmac_pkg::C_BITS-1:0]     c_old,
   input  logic [gtmac_pkg::IDX_BITS-1:0]          row,
   input  logic [gtmac_pkg::IDX_BITS-1:0]          col,
   input  logic signed [gtmac_pkg::DATA_BITS-1:0]  alpha,
   input  logic signed [gtmac_pkg::DATA_BITS-1:0]  beta,
   input  logic                                    take,
   output logic                                    res_vld,
   output gtmac_pkg::gtmac_result_type             res
);
   import gtmac_pkg::*;

   localparam int LO_BITS  = SPLIT_BITS + 1;
   localparam int HI_BITS  = MAG_BITS - SPLIT_BITS;
   localparam int PLO_BITS = LO_BITS + DATA_BITS;
   localparam int PHI_BITS = HI_BITS + DATA_BITS;
   localparam int PB_BITS  = C_BITS + DATA_BITS;
   localparam int SHIFT    = 8;
   localparam int TOP_LSB  = C_BITS + SHIFT - 1;

   // stage 1: range check
   logic signed [WIDE_BITS-1:0] acc_wide;
   logic                        big;
   logic                        vld1_ff;
   logic                        big1_ff;
   logic                        neg1_ff;
   logic [MAG_BITS-1:0]         mag1_ff;
   logic signed [C_BITS-1:0]    cold1_ff;
   logic [IDX_BITS-1:0]         row1_ff;
   logic [IDX_BITS-1:0]         col1_ff;

   // stage 2: products
   logic signed [LO_BITS-1:0]   lo_s;
   logic signed [HI_BITS-1:0]   hi_s;
   logic signed [PLO_BITS-1:0]  plo_in;
   logic signed [PHI_BITS-1:0]  phi_in;
   logic signed [PB_BITS-1:0]   pb_in;
   logic                        vld2_ff;
   logic                        sat2_ff;
   logic                        neg2_ff;
   logic signed [PLO_BITS-1:0]  plo_ff;
   logic signed [PHI_BITS-1:0]  phi_ff;
   logic signed [PB_BITS-1:0]   pb_ff;
   logic [IDX_BITS-1:0]         row2_ff;
   logic [IDX_BITS-1:0]         col2_ff;

   // stage 3: sum
   logic signed [WIDE_BITS-1:0] sum_in;
   logic                        vld3_ff;
   logic                        sat3_ff;
   logic                        neg3_ff;
   logic signed [WIDE_BITS-1:0] sum_ff;
   logic [IDX_BITS-1:0]         row3_ff;
   logic [IDX_BITS-1:0]         col3_ff;

   // stage 4: floor and saturate, held until taken
   logic [WIDE_BITS-TOP_LSB-1:0] top_bits;
   logic [C_BITS-1:0]            c_in;
   logic                         res_vld_ff;
   logic                         res_vld_in;
   gtmac_result_type             res_ff;

   // flag magnitudes beyond the exact range; those saturate unless alpha is zero
   always_comb begin
      acc_wide = WIDE_BITS'(acc);
      big      = (acc_wide >= BIG_POS) || (acc_wide <= BIG_NEG);
   end

   // split the accumulator so that each multiplier stays narrow
   always_comb begin
      lo_s   = $signed({1'b0, mag1_ff[SPLIT_BITS-1:0]});
      hi_s   = $signed(mag1_ff[MAG_BITS-1:SPLIT_BITS]);
      plo_in = lo_s * alpha;
      phi_in = hi_s * alpha;
      pb_in  = cold1_ff * beta;
   end

   // recombine the partial products with the beta term
   assign sum_in = (WIDE_BITS'(phi_ff) <<< SPLIT_BITS) + WIDE_BITS'(plo_ff)
                 + WIDE_BITS'(pb_ff);

   // floor by 256 is the arithmetic shift; saturate when the top does not agree
   always_comb begin
      top_bits = sum_ff[WIDE_BITS-1:TOP_LSB];
      if (sat3_ff) begin
         c_in = neg3_ff ? C_MIN : C_MAX;
      end else if ((&top_bits) || !(|top_bits)) begin
         c_in = sum_ff[TOP_LSB:SHIFT];
      end else begin
         c_in = sum_ff[WIDE_BITS-1] ? C_MIN : C_MAX;
      end
   end

   // result stays valid until the top level takes it
   always_comb begin
      if (vld3_ff) begin
         res_vld_in = 1'b1;
      end else if (take) begin
         res_vld_in = 1'b0;
      end else begin
         res_vld_in = res_vld_ff;
      end
   end

   // stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff    <= 1'b0;
         vld2_ff    <= 1'b0;
         vld3_ff    <= 1'b0;
         res_vld_ff <= 1'b0;
      end else begin
         vld1_ff    <= go;
         vld2_ff    <= vld1_ff;
         vld3_ff    <= vld2_ff;
         res_vld_ff <= res_vld_in;
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      if (go) begin
         big1_ff  <= big;
         neg1_ff  <= (alpha < 0) != (acc < 0);
         mag1_ff  <= big ? '0 : acc_wide[MAG_BITS-1:0];
         cold1_ff <= c_old;
         row1_ff  <= row;
         col1_ff  <= col;
      end
      if (vld1_ff) begin
         sat2_ff <= big1_ff && (alpha != '0);
         neg2_ff <= neg1_ff;
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         pb_ff   <= pb_in;
         row2_ff <= row1_ff;
         col2_ff <= col1_ff;
      end
      if (vld2_ff) begin
         sat3_ff <= sat2_ff;
         neg3_ff <= neg2_ff;
         sum_ff  <= sum_in;
         row3_ff <= row2_ff;
         col3_ff <= col2_ff;
      end
      if (vld3_ff) begin
         res_ff <= '{c_new: c_in, row: row3_ff, col: col3_ff};
      end
   end

   assign res_vld = res_vld_ff;
   assign res     = res_ff;

endmodule

// ===== design/gemm_tile_4x4_mac_unit.sv =====
// ----------------------------------------------------------------------------
// gemm_tile_4x4_mac_unit: 4x4 tile of C = alpha*A*B + beta*C in fixed point
// A grid of multiply-accumulate cells, one per tile element, with an output
// scaler that turns a selected accumulator and an old C element into C.
// ----------------------------------------------------------------------------
// One request is in work at a time. An accumulate or clear request holds the
// request channel while the sequencer counts down over the grid (TILE_DIM
// capped at four): each row of cells is a chain along which the token and
// the A operand step one cell per cycle, and the last cell adds its product
// in the cycle after it receives them. An emit request passes through the
// four-stage output scaler and lands in the response register; while the
// response is stalled and the scaler holds a second result, the request
// channel waits. A new request is taken while a response still waits to be
// taken. Accumulators saturate to ACC_BITS bits; emit results are rounded
// toward minus infinity and saturated to 32 bits. Write alpha and beta only
// while no request is in work.
// ----------------------------------------------------------------------------
module gemm_tile_4x4_mac_unit #(
   parameter int TILE_DIM = gtmac_pkg::TILE_DIM_DEF,
   parameter int ACC_BITS = gtmac_pkg::ACC_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // request channel
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [1:0]                                req_mode,
   input  logic signed [gtmac_pkg::DATA_BITS-1:0]    req_a_row0,
   input  logic signed [gtmac_pkg::DATA_BITS-1:0]    req_a_row1,
   input  logic signed [gtmac_pkg::DATA_BITS-1:0]    req_a_row2,
   input  logic signed [gtmac_pkg::DATA_BITS-1:0]    req_a_row3,
   input  logic signed [gtmac_pkg::DATA_BITS-1:0]    req_b_col0,
   input  logic signed [gtmac_pkg::DATA_BITS-1:0]    req_b_col1,
   input  logic signed [gtmac_pkg::DATA_BITS-1:0]    req_b_col2,
   input  logic signed [gtmac_pkg::DATA_BITS-1:0]    req_b_col3,
   input  logic [gtmac_pkg::IDX_BITS-1:0]            req_tile_row,
   input  logic [gtmac_pkg::IDX_BITS-1:0]            req_tile_col,
   input  logic signed [gtmac_pkg::C_BITS-1:0]       req_c_old,
   // response channel
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [gtmac_pkg::C_BITS-1:0]       rsp_c_new,
   output logic [gtmac_pkg::IDX_BITS-1:0]            rsp_out_row,
   output logic [gtmac_pkg::IDX_BITS-1:0]            rsp_out_col,
   // configuration
   input  logic                                      csr_write,
   input  logic [gtmac_pkg::CSR_IDX_BITS-1:0]        csr_index,
   input  logic [gtmac_pkg::DATA_BITS-1:0]           csr_wdata
);
   import gtmac_pkg::*;

   localparam int GRID     = (TILE_DIM < LANES) ? TILE_DIM : LANES;
   localparam int CNT_BITS = $clog2(GRID);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ACC  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]                  state_ff;
   logic [1:0]                  state_in;
   logic [CNT_BITS-1:0]         cnt_ff;
   logic [CNT_BITS-1:0]         cnt_in;
   logic                        fire0_ff;
   logic                        fire0_in;
   logic                        clr0_ff;
   logic                        clr0_in;
   logic                        emit_go_ff;
   logic                        emit_go_in;
   logic                        req_accept;

   logic signed [DATA_BITS-1:0] a_ff [LANES];
   logic signed [DATA_BITS-1:0] b_ff [LANES];
   logic [IDX_BITS-1:0]         row_ff;
   logic [IDX_BITS-1:0]         col_ff;
   logic signed [C_BITS-1:0]    cold_ff;
   logic signed [DATA_BITS-1:0] alpha_ff;
   logic signed [DATA_BITS-1:0] beta_ff;

   gtmac_link_type              link_w   [GRID][GRID+1];
   logic signed [ACC_BITS-1:0]  cell_acc [GRID][GRID];
   logic signed [ACC_BITS-1:0]  acc_sel;

   logic                        res_vld;
   gtmac_result_type            res;
   logic                        res_take;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   gtmac_result_type            rsp_data_ff;

   // take a request only when nothing is in work
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // scaler result moves into the response register when it is free
   assign res_take = res_vld && (!rsp_valid_ff || !rsp_stall);

   // sequencer: start the cell chains or the scaler, wait for them to drain
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      fire0_in   = 1'b0;
      clr0_in    = 1'b0;
      emit_go_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_mode) inside
                  MODE_ACC, MODE_CLEAR: begin
                     state_in = ST_ACC;
                     cnt_in   = CNT_BITS'(GRID - 1);
                     fire0_in = 1'b1;
                     clr0_in  = (req_mode == MODE_CLEAR);
                  end
                  MODE_EMIT: begin
                     state_in   = ST_EMIT;
                     emit_go_in = 1'b1;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ACC: begin
            if (cnt_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         fire0_ff   <= 1'b0;
         clr0_ff    <= 1'b0;
         emit_go_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         fire0_ff   <= fire0_in;
         clr0_ff    <= clr0_in;
         emit_go_ff <= emit_go_in;
      end
   end

   // capture request operands
   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_ff[0] <= req_a_row0;
         a_ff[1] <= req_a_row1;
         a_ff[2] <= req_a_row2;
         a_ff[3] <= req_a_row3;
         b_ff[0] <= req_b_col0;
         b_ff[1] <= req_b_col1;
         b_ff[2] <= req_b_col2;
         b_ff[3] <= req_b_col3;
         row_ff  <= req_tile_row;
         col_ff  <= req_tile_col;
         cold_ff <= req_c_old;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         beta_ff  <= BETA_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ALPHA: alpha_ff <= $signed(csr_wdata);
            CSR_BETA:  beta_ff  <= $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // cell grid: each row is a chain fed at its left end
   for (genvar r = 0; r < GRID; r++) begin : g_row
      assign link_w[r][0] = '{fire: fire0_ff, clear: clr0_ff, a: a_ff[r]};
      for (genvar c = 0; c < GRID; c++) begin : g_col
         gtmac_cell #(
            .ACC_BITS (ACC_BITS)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .link_in  (link_w[r][c]),
            .b_in     (b_ff[c]),
            .link_out (link_w[r][c+1]),
            .acc_out  (cell_acc[r][c])
         );
      end
   end

   // pick the addressed accumulator; elements outside the grid read as zero
   always_comb begin
      acc_sel = '0;
      for (int r = 0; r < GRID; r++) begin
         for (int c = 0; c < GRID; c++) begin
            if ((row_ff == IDX_BITS'(r)) && (col_ff == IDX_BITS'(c))) begin
               acc_sel = cell_acc[r][c];
            end
         end
      end
   end

   gtmac_scale #(
      .ACC_BITS (ACC_BITS)
   ) u_scale (
      .clock   (clock),
      .reset   (reset),
      .go      (emit_go_ff),
      .acc     (acc_sel),
      .c_old   (cold_ff),
      .row     (row_ff),
      .col     (col_ff),
      .alpha   (alpha_ff),
      .beta    (beta_ff),
      .take    (res_take),
      .res_vld (res_vld),
      .res     (res)
   );

   // response register: load a new result, drop the old one once taken
   always_comb begin
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_c_new   = $signed(rsp_data_ff.c_new);
   assign rsp_out_row = rsp_data_ff.row;
   assign rsp_out_col = rsp_data_ff.col;

endmodule

// ===== sim/gemm_tile_4x4_mac_unit_tb.sv =====
// ----------------------------------------------------------------------------
// gemm_tile_4x4_mac_unit_tb: self-checking bench for the 4x4 GEMM tile MAC
// A queue-fed driver offers accumulate, clear, emit and unused-mode requests
// with random gaps. A monitor with random and long stalls checks every emitted
// C element against a bit-true tile model kept in the bench. Directed requests
// cover operand and C extremes, a run that builds large accumulators of both
// signs and gain extremes.
// Random traffic follows clear/accumulate/emit sequences mixed with noise.
// ----------------------------------------------------------------------------
module gemm_tile_4x4_mac_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gtmac_pkg::*;

   localparam int     SETTLE_CYCLES = 20;
   localparam int     LONG_HOLD     = 200;
   localparam int     RANDOM_ITEMS  = 480;
   localparam int     SAT_RUN       = 24;
   localparam int     PRINT_LIMIT   = 40;
   localparam longint ACC_TOP       = (longint'(1) <<< (ACC_BITS_DEF - 1)) - 1;
   localparam longint ACC_BOTTOM    = -ACC_TOP - 1;
   localparam longint HUGE_ACC      = longint'(1) <<< 47;
   localparam longint C_TOP         = 64'sd2147483647;
   localparam longint C_BOTTOM      = -64'sd2147483648;

   // one request as queued for the driver, with its lead-in gap
   typedef struct packed {
      logic [4:0]                  gap;
      logic [1:0]                  mode;
      logic [3:0][DATA_BITS-1:0]   a;
      logic [3:0][DATA_BITS-1:0]   b;
      logic [IDX_BITS-1:0]         row;
      logic [IDX_BITS-1:0]         col;
      logic [C_BITS-1:0]           c_old;
   } tile_request_type;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_valid  = 1'b0;
   logic                        req_stall;
   logic [1:0]                  req_mode   = MODE_ACC;
   logic signed [DATA_BITS-1:0] req_a_row0 = '0;
   logic signed [DATA_BITS-1:0] req_a_row1 = '0;
   logic signed [DATA_BITS-1:0] req_a_row2 = '0;
   logic signed [DATA_BITS-1:0] req_a_row3 = '0;
   logic signed [DATA_BITS-1:0] req_b_col0 = '0;
   logic signed [DATA_BITS-1:0] req_b_col1 = '0;
   logic signed [DATA_BITS-1:0] req_b_col2 = '0;
   logic signed [DATA_BITS-1:0] req_b_col3 = '0;
   logic [IDX_BITS-1:0]         req_tile_row = '0;
   logic [IDX_BITS-1:0]         req_tile_col = '0;
   logic signed [C_BITS-1:0]    req_c_old  = '0;
   logic                        rsp_valid;
   logic                        rsp_stall  = 1'b0;
   logic signed [C_BITS-1:0]    rsp_c_new;
   logic [IDX_BITS-1:0]         rsp_out_row;
   logic [IDX_BITS-1:0]         rsp_out_col;
   logic                        csr_write  = 1'b0;
   logic [CSR_IDX_BITS-1:0]     csr_index  = CSR_ALPHA;
   logic [DATA_BITS-1:0]        csr_wdata  = '0;

   // tile model state and its gain copies
   longint                      tile_acc [4][4];
   logic signed [DATA_BITS-1:0] alpha_now = ALPHA_RESET;
   logic signed [DATA_BITS-1:0] beta_now  = BETA_RESET;

   tile_request_type pending_requests[$];
   gtmac_result_type expected_c[$];
   tile_request_type on_bus;
   int               gap_count;
   int               gap_ceiling   = 17;
   int               stall_ceiling = 17;
   int               stall_left;
   int               hold_left;
   int               hold_tokens   = 0;
   int               hold_seen;
   int               error_count   = 0;

   gemm_tile_4x4_mac_unit uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_a_row0   (req_a_row0),
      .req_a_row1   (req_a_row1),
      .req_a_row2   (req_a_row2),
      .req_a_row3   (req_a_row3),
      .req_b_col0   (req_b_col0),
      .req_b_col1   (req_b_col1),
      .req_b_col2   (req_b_col2),
      .req_b_col3   (req_b_col3),
      .req_tile_row (req_tile_row),
      .req_tile_col (req_tile_col),
      .req_c_old    (req_c_old),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_c_new    (rsp_c_new),
      .rsp_out_row  (rsp_out_row),
      .rsp_out_col  (rsp_out_col),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- model

   // add a product into an accumulator, clamping to the accumulator range
   function automatic longint sat_accumulate(input longint acc, input longint prod);
      longint sum;
      sum = acc + prod;
      if (sum > ACC_TOP) sum = ACC_TOP;
      else if (sum < ACC_BOTTOM) sum = ACC_BOTTOM;
      return sum;
   endfunction

   // alpha*acc + beta*c_old, floored to Q16.16 and clamped to 32 bits
   function automatic logic [C_BITS-1:0] scale_c_element(input longint acc,
                                                         input longint c_prev);
      longint sum;
      if (alpha_now != 0 && (acc >= HUGE_ACC || acc <= -HUGE_ACC))
         return ((alpha_now < 0) != (acc < 0)) ? C_MIN : C_MAX;
      if (acc >= HUGE_ACC || acc <= -HUGE_ACC) acc = 0;
      sum = longint'(alpha_now) * acc + longint'(beta_now) * c_prev;
      sum = sum >>> 8;
      if (sum > C_TOP) return C_MAX;
      if (sum < C_BOTTOM) return C_MIN;
      return sum[C_BITS-1:0];
   endfunction

   // advance the tile model by one accepted request
   task automatic apply_request(input tile_request_type r);
      gtmac_result_type res;
      int               rr;
      int               cc;
      case (r.mode)
         MODE_ACC, MODE_CLEAR: begin
            for (rr = 0; rr < 4; rr++) begin
               for (cc = 0; cc < 4; cc++) begin
                  if (r.mode == MODE_CLEAR) tile_acc[rr][cc] = 0;
                  tile_acc[rr][cc] = sat_accumulate(tile_acc[rr][cc],
                     longint'($signed(r.a[rr])) * longint'($signed(r.b[cc])));
               end
            end
         end
         MODE_EMIT: begin
            res.c_new = scale_c_element(tile_acc[r.row][r.col], longint'($signed(r.c_old)));
            res.row   = r.row;
            res.col   = r.col;
            expected_c.push_back(res);
         end
         default: ;
      endcase
   endtask

   task automatic flag_error(input string msg);
      if (error_count < PRINT_LIMIT) $display("[%0t] ERROR: %s", $realtime, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_count = 0;
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) tile_acc[r][c] = 0;
      end else begin
         // a request went in at this edge
         if (req_valid && !req_stall) apply_request(on_bus);
         // offer the next request once its gap has passed
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() > 0 && gap_count >= pending_requests[0].gap) begin
               on_bus = pending_requests.pop_front();
               gap_count = 0;
               req_valid    <= 1'b1;
               req_mode     <= on_bus.mode;
               req_a_row0   <= on_bus.a[0];
               req_a_row1   <= on_bus.a[1];
               req_a_row2   <= on_bus.a[2];
               req_a_row3   <= on_bus.a[3];
               req_b_col0   <= on_bus.b[0];
               req_b_col1   <= on_bus.b[1];
               req_b_col2   <= on_bus.b[2];
               req_b_col3   <= on_bus.b[3];
               req_tile_row <= on_bus.row;
               req_tile_col <= on_bus.col;
               req_c_old    <= on_bus.c_old;
            end else begin
               req_valid <= 1'b0;
               if (pending_requests.size() > 0) gap_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      gtmac_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
         hold_seen  = 0;
      end else begin
         // check a response taken at this edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_c.size() == 0) begin
               flag_error($sformatf("unexpected response c_new=%h row=%0d col=%0d",
                                    rsp_c_new, rsp_out_row, rsp_out_col));
            end else begin
               want = expected_c.pop_front();
               if (rsp_c_new !== want.c_new)
                  flag_error($sformatf("c_new %h, want %h (row %0d col %0d)",
                                       rsp_c_new, want.c_new, want.row, want.col));
               if (rsp_out_row !== want.row)
                  flag_error($sformatf("out_row %0d, want %0d", rsp_out_row, want.row));
               if (rsp_out_col !== want.col)
                  flag_error($sformatf("out_col %0d, want %0d", rsp_out_col, want.col));
            end
            stall_left = $urandom_range(0, stall_ceiling);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         // long hold-off on request from the stimulus
         if (hold_seen != hold_tokens) begin
            hold_seen = hold_tokens;
            hold_left = LONG_HOLD;
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_stall <= (stall_left > 0) || (hold_left > 0);
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic logic [DATA_BITS-1:0] pick_operand();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return DATA_BITS'($urandom());
      endcase
   endfunction

   function automatic logic [C_BITS-1:0] pick_c_old();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [DATA_BITS-1:0] pick_gain();
      case ($urandom_range(0, 6))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'h0100;
         4:       return 16'hFF00;
         default: return DATA_BITS'($urandom());
      endcase
   endfunction

   function automatic tile_request_type make_request(input logic [1:0] mode);
      tile_request_type r;
      int               i;
      r.gap  = '0;
      r.mode = mode;
      for (i = 0; i < 4; i++) begin
         r.a[i] = pick_operand();
         r.b[i] = pick_operand();
      end
      r.row   = IDX_BITS'($urandom_range(0, 3));
      r.col   = IDX_BITS'($urandom_range(0, 3));
      r.c_old = pick_c_old();
      return r;
   endfunction

   function automatic tile_request_type fixed_request(input logic [1:0] mode,
      input logic [63:0] a, input logic [63:0] b, input int row, input int col,
      input logic [C_BITS-1:0] c_prev);
      tile_request_type r;
      r.gap   = '0;
      r.mode  = mode;
      r.a     = a;
      r.b     = b;
      r.row   = IDX_BITS'(row);
      r.col   = IDX_BITS'(col);
      r.c_old = c_prev;
      return r;
   endfunction

   task automatic queue_request(input tile_request_type r);
      r.gap = 5'($urandom_range(0, gap_ceiling));
      pending_requests.push_back(r);
   endtask

   // hold until every request is in and every result is out, then settle
   task automatic drain_and_settle();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_c.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_gain(input logic [CSR_IDX_BITS-1:0] idx,
                             input logic [DATA_BITS-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_ALPHA) alpha_now = value;
      else beta_now = value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   task automatic emit_all_cells();
      int r;
      int c;
      for (r = 0; r < 4; r++)
         for (c = 0; c < 4; c++) begin
            tile_request_type q;
            q = make_request(MODE_EMIT);
            q.row = IDX_BITS'(r);
            q.col = IDX_BITS'(c);
            queue_request(q);
         end
   endtask

   initial begin
      int               counted;
      int               n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset gains and an empty tile
      queue_request(fixed_request(MODE_EMIT, '0, '0, 0, 0, 32'h7FFF_FFFF));
      queue_request(fixed_request(MODE_EMIT, '0, '0, 3, 3, 32'h8000_0000));
      // operand extremes through clear and accumulate, plus an ignored mode
      queue_request(fixed_request(MODE_CLEAR, {16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF},
                                  {16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF}, 0, 0, '0));
      queue_request(fixed_request(MODE_ACC, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
                                  {16'h8000, 16'h8000, 16'h7FFF, 16'h8000}, 0, 0, '0));
      queue_request(fixed_request(MODE_NONE, {4{16'h7FFF}}, {4{16'h7FFF}}, 3, 3, '1));
      queue_request(fixed_request(MODE_EMIT, '0, '0, 0, 0, 32'h7FFF_FFFF));
      queue_request(fixed_request(MODE_EMIT, '0, '0, 1, 1, 32'h8000_0000));
      queue_request(fixed_request(MODE_EMIT, '0, '0, 3, 2, 32'hFFFF_FFFF));
      queue_request(fixed_request(MODE_EMIT, '0, '0, 2, 3, 32'h0000_0001));
      drain_and_settle();

      // extreme gains on built-up accumulators, then on a cleared tile
      write_gain(CSR_ALPHA, 16'h7FFF);
      write_gain(CSR_BETA, 16'h8000);
      queue_request(fixed_request(MODE_EMIT, '0, '0, 0, 0, 32'h8000_0000));
      queue_request(fixed_request(MODE_EMIT, '0, '0, 1, 1, 32'h7FFF_FFFF));
      queue_request(fixed_request(MODE_EMIT, '0, '0, 2, 0, 32'h0000_0000));
      queue_request(fixed_request(MODE_CLEAR, '0, '0, 0, 0, '0));
      queue_request(fixed_request(MODE_EMIT, '0, '0, 0, 0, 32'h0001_0000));
      queue_request(fixed_request(MODE_EMIT, '0, '0, 3, 3, 32'hFFFF_0000));
      drain_and_settle();

      // build large accumulators of both signs, back to back
      gap_ceiling   = 0;
      stall_ceiling = 0;
      for (n = 0; n < SAT_RUN; n++)
         pending_requests.push_back(fixed_request((n == 0) ? MODE_CLEAR : MODE_ACC,
            {16'h0001, 16'h7FFF, 16'h8000, 16'h8000},
            {16'h0001, 16'h8000, 16'h7FFF, 16'h8000}, 0, 0, '0));
      drain_and_settle();
      gap_ceiling   = 17;
      stall_ceiling = 17;
      write_gain(CSR_ALPHA, 16'h0100);
      write_gain(CSR_BETA, pick_gain());
      emit_all_cells();
      drain_and_settle();
      write_gain(CSR_ALPHA, 16'hFFFF);
      emit_all_cells();
      drain_and_settle();
      write_gain(CSR_ALPHA, 16'h0000);
      emit_all_cells();
      drain_and_settle();

      // receiver holds off while the sender keeps pushing
      write_gain(CSR_ALPHA, 16'h0100);
      gap_ceiling = 0;
      hold_tokens++;
      queue_request(make_request(MODE_CLEAR));
      queue_request(make_request(MODE_ACC));
      repeat (24) queue_request(make_request(MODE_EMIT));
      drain_and_settle();
      gap_ceiling = 17;

      // random clear / accumulate / emit sequences
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if ($urandom_range(0, 5) == 0) begin
            drain_and_settle();
            n = $urandom_range(0, 2);
            if (n != 1) write_gain(CSR_ALPHA, pick_gain());
            if (n != 0) write_gain(CSR_BETA, pick_gain());
         end
         gap_ceiling   = ($urandom_range(0, 3) == 0) ? 0 : 17;
         stall_ceiling = ($urandom_range(0, 3) == 0) ? 0 : 17;
         if ($urandom_range(0, 3) != 0) begin
            queue_request(make_request(MODE_CLEAR));
            counted++;
         end
         n = $urandom_range(0, 6);
         repeat (n) begin
            queue_request(make_request(MODE_ACC));
            counted++;
            if ($urandom_range(0, 15) == 0) queue_request(make_request(MODE_NONE));
         end
         n = $urandom_range(1, 5);
         repeat (n) begin
            queue_request(make_request(MODE_EMIT));
            counted++;
         end
         if ($urandom_range(0, 7) == 0) queue_request(make_request(MODE_NONE));
         while (pending_requests.size() > 8) @(negedge clock);
      end

      drain_and_settle();
      if (error_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   // overall run limit
   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/gtmac_pkg.sv
design/gtmac_cell.sv
design/gtmac_scale.sv
design/gemm_tile_4x4_mac_unit.sv
sim/gemm_tile_4x4_mac_unit_tb.sv
